// ===== hdl/indicator_based_survivor_selection_core_assert.svh =====
// assertion macros for the survivor selection core and its checker
`ifndef INDICATOR_BASED_SURVIVOR_SELECTION_CORE_ASSERT_SVH
`define INDICATOR_BASED_SURVIVOR_SELECTION_CORE_ASSERT_SVH

// condition holds in the same cycle
`define IBSS_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ibss assertion failed");

// condition holds in the following cycle
`define IBSS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ibss assertion failed");

`endif

// ===== hdl/ibss_pkg.sv =====
// shared types, constants and helpers of the survivor selection core
package ibss_pkg;

  localparam int MAX_POPULATION = 64;
  localparam int MAX_OBJECTIVES = 8;

  localparam int POP_W = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
  localparam int OBJ_W = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;
  localparam int CNT_W = $clog2(MAX_POPULATION + 1);
  localparam int OBJ_ADDR_W = $clog2(MAX_POPULATION * MAX_OBJECTIVES);

  // fixed point constants
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
  localparam logic [47:0] EXP_HI_LIM = 48'd1048576;   // 16.0 in q16.16
  localparam logic [47:0] EXP_LO_LIM = 48'd1966080;   // 30.0 in q16.16
  localparam logic [32:0] TERM_CAP = 33'h100000000;
  localparam logic [33:0] ONE_Q32 = 34'h100000000;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [3:0] SERIES_TERMS = 4'd12;

  // shared divider widths
  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 32;
  localparam int DIV_C_W = $clog2(DIV_N_W + 1);

  typedef enum logic [1:0] {
    CFG_KEEP_COUNT      = 2'd0,
    CFG_OBJECTIVE_COUNT = 2'd1
  } ibss_cfg_e;

  typedef struct packed {
    logic signed [31:0] obj_value;
    logic signed [31:0] fitness_value;
    logic               last_objective;
    logic               last_individual;
  } ibss_cmd_t;

  typedef struct packed {
    logic [5:0] removed_index;
    logic       removed_valid;
    logic       last_result;
  } ibss_result_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] dividend;
    logic [DIV_D_W-1:0] divisor;
  } ibss_div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] quotient;
  } ibss_div_rsp_t;

  function automatic logic [OBJ_ADDR_W-1:0] ibss_obj_addr(input logic [POP_W-1:0] ind,
                                                          input logic [OBJ_W-1:0] obj);
    return OBJ_ADDR_W'(int'(ind) * MAX_OBJECTIVES + int'(obj));
  endfunction

endpackage

// ===== hdl/ibss_div.sv =====
// shared restoring divider, one quotient bit per cycle
module ibss_div import ibss_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ibss_div_req_t req_i,
  output ibss_div_rsp_t rsp_o
);

  logic [DIV_D_W-1:0] rem_q, rem_d;
  logic [DIV_D_W-1:0] dvs_q, dvs_d;
  logic [DIV_N_W-1:0] quo_q, quo_d;
  logic [DIV_C_W-1:0] cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [DIV_D_W:0]   trial;

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DIV_N_W-1]};
    if (req_i.start) begin
      rem_d = '0;
      dvs_d = req_i.divisor;
      quo_d = req_i.dividend;
      cnt_d = DIV_C_W'(DIV_N_W);
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DIV_D_W'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[DIV_N_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_D_W-1:0];
        quo_d = {quo_q[DIV_N_W-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == DIV_C_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
      quo_q  <= quo_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== hdl/indicator_based_survivor_selection_core.sv =====
// survivor selection core: population load, sequencer, stores and shared multiplier
//
// Loads one objective value per start pulse while busy_o stays low.
// The word flagged last_individual starts a selection run with busy_o high:
// normalization divides each value lying strictly inside its objective's range
// on the shared 48-step divider, the scale pass runs over every ordered pair of
// individuals for each objective, and each removal searches for the minimum
// fitness and then, per survivor, reads the indicator and computes the
// exponential (one divide for the exponent and eleven for the series terms, all
// on the one shared divider). Each removed index appears on result_o for
// one cycle with result_valid_o; the receiver cannot stall, and last_result marks
// the end of the run, after which busy_o falls on the next cycle.
module indicator_based_survivor_selection_core import ibss_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  ibss_cmd_t    cmd_i,
  output logic         busy_o,
  output logic         result_valid_o,
  output ibss_result_t result_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [7:0]   cfg_data_i
);

  typedef enum logic [20:0] {
    ST_IDLE    = 21'h000001,
    ST_N_RD    = 21'h000002,
    ST_N_CALC  = 21'h000004,
    ST_N_WAIT  = 21'h000008,
    ST_S_RD    = 21'h000010,
    ST_S_ACC   = 21'h000020,
    ST_F_RD    = 21'h000040,
    ST_F_CMP   = 21'h000080,
    ST_R_EMIT  = 21'h000100,
    ST_R_SCALE = 21'h000200,
    ST_U_CHK   = 21'h000400,
    ST_U_IRD   = 21'h000800,
    ST_U_IACC  = 21'h001000,
    ST_U_DIV   = 21'h002000,
    ST_U_MULY  = 21'h004000,
    ST_U_MULU  = 21'h008000,
    ST_U_SDIVS = 21'h010000,
    ST_U_SDIV  = 21'h020000,
    ST_U_SHIFT = 21'h040000,
    ST_U_FIT   = 21'h080000,
    ST_FINISH  = 21'h100000
  } ibss_state_e;

  ibss_state_e state_q, state_d;

  logic [5:0]              keep_q, keep_d;
  logic [3:0]              objn_q, objn_d;
  logic [CNT_W-1:0]        loaded_q, loaded_d;
  logic [OBJ_W-1:0]        pos_q, pos_d;
  logic signed [31:0]      omax_q [MAX_OBJECTIVES];
  logic signed [31:0]      omax_d [MAX_OBJECTIVES];
  logic signed [31:0]      omin_q [MAX_OBJECTIVES];
  logic signed [31:0]      omin_d [MAX_OBJECTIVES];
  logic [MAX_POPULATION-1:0] alive_q, alive_d;
  logic [CNT_W-1:0]        alive_cnt_q, alive_cnt_d;
  logic [POP_W-1:0]        i_q, i_d, k_q, k_d, e_q, e_d;
  logic [OBJ_W-1:0]        j_q, j_d;
  logic signed [17:0]      best_q, best_d;
  logic [16:0]             sacc_q, sacc_d;
  logic signed [31:0]      efit_q, efit_d;
  logic                    found_q, found_d;
  logic [16:0]             se_q, se_d;
  logic signed [7:0]       nexp_q, nexp_d;
  logic [31:0]             u_q, u_d;
  logic [33:0]             sum_q, sum_d;
  logic [3:0]              kser_q, kser_d;
  logic [32:0]             tv_q, tv_d;
  logic signed [65:0]      mul_q;
  logic signed [32:0]      mul_a, mul_b;
  logic                    res_valid_q, res_valid_d;
  ibss_result_t            res_q, res_d;

  // stores
  logic signed [31:0] obj_mem [MAX_POPULATION*MAX_OBJECTIVES];
  logic [16:0]        norm_mem [MAX_POPULATION*MAX_OBJECTIVES];
  logic signed [31:0] fit_mem [MAX_POPULATION];
  logic [16:0]        sc_mem [MAX_POPULATION];
  logic signed [31:0] obj_rd_q, fit_rd_q;
  logic [16:0]        norm_a_q, norm_b_q, sc_rd_q;

  logic                  obj_we, norm_we, fit_we, fit_re, sc_we, sc_re;
  logic [OBJ_ADDR_W-1:0] obj_waddr, obj_raddr, norm_waddr, norm_ra, norm_rb;
  logic [16:0]           norm_wdata, sc_wdata;
  logic signed [31:0]    fit_wdata;
  logic [POP_W-1:0]      fit_waddr, fit_raddr;

  ibss_div_req_t div_req;
  ibss_div_rsp_t div_rsp;

  // helpers
  logic [5:0]         keep_eff;
  logic [3:0]         m_eff;
  logic               j_last, i_last, k_last, accept;
  logic [OBJ_W-1:0]   mm_idx;
  logic signed [17:0] diff, nb, nb_neg;
  logic [16:0]        nb_abs, s_new;
  logic [21:0]        gain;
  logic signed [21:0] a_val, q_pos;
  logic signed [32:0] v_lo, hi_lo;
  logic signed [33:0] fsum;
  logic [7:0]         shamt;
  logic               do_nadv, do_kadv, do_uadv;

  ibss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign cfg_ready_o    = (state_q == ST_IDLE);
  assign accept         = start_i && (state_q == ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  assign keep_eff = (keep_q == 6'd0) ? 6'd1 : keep_q;
  assign m_eff    = (objn_q == 4'd0) ? 4'd1 :
                    ((int'(objn_q) > MAX_OBJECTIVES) ? 4'(MAX_OBJECTIVES) : objn_q);
  assign j_last   = (int'(j_q) + 1) >= int'(m_eff);
  assign i_last   = (int'(i_q) + 1) >= int'(loaded_q);
  assign k_last   = (int'(k_q) + 1) >= int'(loaded_q);
  assign mm_idx   = (state_q == ST_IDLE) ? pos_q : j_q;

  assign diff   = $signed({1'b0, norm_a_q}) - $signed({1'b0, norm_b_q});
  assign nb     = ((j_q == '0) || (diff > best_q)) ? diff : best_q;
  assign nb_neg = -nb;
  assign nb_abs = nb[17] ? nb_neg[16:0] : nb[16:0];
  assign gain   = ({5'b0, nb_abs} << 4) + ({5'b0, nb_abs} << 2);
  assign q_pos  = $signed({1'b0, div_rsp.quotient[20:0]});
  assign a_val  = (best_q > 18'sd0) ? -q_pos : q_pos;
  assign v_lo   = $signed({obj_rd_q[31], obj_rd_q}) - $signed({omin_q[mm_idx][31], omin_q[mm_idx]});
  assign hi_lo  = $signed({omax_q[mm_idx][31], omax_q[mm_idx]})
                - $signed({omin_q[mm_idx][31], omin_q[mm_idx]});
  assign fsum   = $signed({{2{fit_rd_q[31]}}, fit_rd_q}) + $signed({1'b0, tv_q});
  assign shamt  = 8'sd16 - nexp_q;

  always_comb begin
    state_d     = state_q;
    keep_d      = keep_q;
    objn_d      = objn_q;
    loaded_d    = loaded_q;
    pos_d       = pos_q;
    omax_d      = omax_q;
    omin_d      = omin_q;
    alive_d     = alive_q;
    alive_cnt_d = alive_cnt_q;
    i_d         = i_q;
    k_d         = k_q;
    e_d         = e_q;
    j_d         = j_q;
    best_d      = best_q;
    sacc_d      = sacc_q;
    efit_d      = efit_q;
    found_d     = found_q;
    se_d        = se_q;
    nexp_d      = nexp_q;
    u_d         = u_q;
    sum_d       = sum_q;
    kser_d      = kser_q;
    tv_d        = tv_q;
    mul_a       = '0;
    mul_b       = '0;
    res_valid_d = 1'b0;
    res_d       = res_q;
    obj_we      = 1'b0;
    obj_waddr   = ibss_obj_addr(loaded_q[POP_W-1:0], pos_q);
    obj_raddr   = ibss_obj_addr(i_q, j_q);
    norm_we     = 1'b0;
    norm_waddr  = ibss_obj_addr(i_q, j_q);
    norm_wdata  = '0;
    norm_ra     = ibss_obj_addr(k_q, j_q);
    norm_rb     = ibss_obj_addr(i_q, j_q);
    fit_we      = 1'b0;
    fit_waddr   = k_q;
    fit_wdata   = cmd_i.fitness_value;
    fit_re      = 1'b0;
    fit_raddr   = i_q;
    s_new       = sacc_q;
    sc_we       = 1'b0;
    sc_wdata    = '0;
    sc_re       = 1'b0;
    div_req     = '0;
    do_nadv     = 1'b0;
    do_kadv     = 1'b0;
    do_uadv     = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_KEEP_COUNT:      keep_d = cfg_data_i[5:0];
        CFG_OBJECTIVE_COUNT: objn_d = cfg_data_i[3:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (int'(loaded_q) < MAX_POPULATION) begin
            obj_we = 1'b1;
            if (pos_q == '0) begin
              fit_we    = 1'b1;
              fit_waddr = loaded_q[POP_W-1:0];
              alive_d[loaded_q[POP_W-1:0]] = 1'b1;
            end
            if (cmd_i.obj_value > omax_q[mm_idx]) omax_d[mm_idx] = cmd_i.obj_value;
            if (cmd_i.obj_value < omin_q[mm_idx]) omin_d[mm_idx] = cmd_i.obj_value;
            if (cmd_i.last_objective || cmd_i.last_individual) begin
              loaded_d = loaded_q + 1'b1;
              pos_d    = '0;
            end else if ((int'(pos_q) + 1) < MAX_OBJECTIVES) begin
              pos_d = pos_q + 1'b1;
            end
          end
          if (cmd_i.last_individual) begin
            alive_cnt_d = loaded_d;
            i_d = '0;
            j_d = '0;
            if (int'(loaded_d) <= int'(keep_eff)) begin
              // nothing to remove
              res_valid_d = 1'b1;
              res_d       = '{removed_index: 6'd0, removed_valid: 1'b0, last_result: 1'b1};
              state_d     = ST_FINISH;
            end else begin
              state_d = ST_N_RD;
            end
          end
        end
      end
      ST_N_RD: state_d = ST_N_CALC;
      ST_N_CALC: begin
        if ((hi_lo > 33'sd0) && (obj_rd_q > omin_q[mm_idx]) && (obj_rd_q < omax_q[mm_idx])) begin
          div_req.start    = 1'b1;
          div_req.dividend = {v_lo[31:0], 16'b0};
          div_req.divisor  = hi_lo[31:0];
          state_d          = ST_N_WAIT;
        end else begin
          norm_we    = 1'b1;
          norm_wdata = ((hi_lo > 33'sd0) && (obj_rd_q >= omax_q[mm_idx])) ? ONE_Q16 : 17'd0;
          do_nadv    = 1'b1;
        end
      end
      ST_N_WAIT: begin
        if (div_rsp.done) begin
          norm_we    = 1'b1;
          norm_wdata = div_rsp.quotient[16:0];
          do_nadv    = 1'b1;
        end
      end
      ST_S_RD: begin
        if (k_q == i_q) begin
          do_kadv = 1'b1;
        end else begin
          state_d = ST_S_ACC;
        end
      end
      ST_S_ACC: begin
        if (!j_last) begin
          best_d  = nb;
          j_d     = j_q + 1'b1;
          state_d = ST_S_RD;
        end else begin
          j_d     = '0;
          s_new   = (nb_abs > sacc_q) ? nb_abs : sacc_q;
          do_kadv = 1'b1;
        end
      end
      ST_F_RD: begin
        fit_re  = 1'b1;
        state_d = ST_F_CMP;
      end
      ST_F_CMP: begin
        if (alive_q[i_q] && (!found_q || (fit_rd_q < efit_q))) begin
          e_d     = i_q;
          efit_d  = fit_rd_q;
          found_d = 1'b1;
        end
        if (!i_last) begin
          i_d     = i_q + 1'b1;
          state_d = ST_F_RD;
        end else begin
          state_d = ST_R_EMIT;
        end
      end
      ST_R_EMIT: begin
        res_valid_d = 1'b1;
        res_d.removed_index = 6'(e_q);
        res_d.removed_valid = 1'b1;
        res_d.last_result   = (int'(alive_cnt_q) - 1) <= int'(keep_eff);
        alive_d[e_q] = 1'b0;
        alive_cnt_d  = alive_cnt_q - 1'b1;
        sc_re        = 1'b1;
        state_d      = ((int'(alive_cnt_q) - 1) <= int'(keep_eff)) ? ST_FINISH : ST_R_SCALE;
      end
      ST_R_SCALE: begin
        se_d = sc_rd_q;
        if (sc_rd_q == 17'd0) begin
          // zero scale leaves every fitness unchanged
          i_d     = '0;
          found_d = 1'b0;
          state_d = ST_F_RD;
        end else begin
          k_d     = '0;
          state_d = ST_U_CHK;
        end
      end
      ST_U_CHK: begin
        if (!alive_q[k_q]) begin
          do_uadv = 1'b1;
        end else begin
          fit_re    = 1'b1;
          fit_raddr = k_q;
          j_d       = '0;
          state_d   = ST_U_IRD;
        end
      end
      ST_U_IRD: begin
        norm_ra = ibss_obj_addr(e_q, j_q);
        norm_rb = ibss_obj_addr(k_q, j_q);
        state_d = ST_U_IACC;
      end
      ST_U_IACC: begin
        best_d = nb;
        if (!j_last) begin
          j_d     = j_q + 1'b1;
          state_d = ST_U_IRD;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {10'b0, gain, 16'b0};
          div_req.divisor  = {15'b0, se_q};
          state_d          = ST_U_DIV;
        end
      end
      ST_U_DIV: begin
        if (div_rsp.done) begin
          if ((best_q > 18'sd0) && (div_rsp.quotient > EXP_LO_LIM)) begin
            tv_d    = '0;
            state_d = ST_U_FIT;
          end else if ((best_q < 18'sd0) && (div_rsp.quotient > EXP_HI_LIM)) begin
            tv_d    = TERM_CAP;
            state_d = ST_U_FIT;
          end else begin
            mul_a   = {{11{a_val[21]}}, a_val};
            mul_b   = $signed({16'b0, LOG2E_Q16});
            state_d = ST_U_MULY;
          end
        end
      end
      ST_U_MULY: begin
        // integer and fraction of the base-2 exponent
        nexp_d  = mul_q[39:32];
        mul_a   = $signed({17'b0, mul_q[31:16]});
        mul_b   = $signed({1'b0, LN2_Q32});
        state_d = ST_U_MULU;
      end
      ST_U_MULU: begin
        u_d     = mul_q[47:16];
        sum_d   = ONE_Q32 + {2'b0, mul_q[47:16]};
        kser_d  = 4'd2;
        mul_a   = $signed({1'b0, mul_q[47:16]});
        mul_b   = $signed({1'b0, mul_q[47:16]});
        state_d = ST_U_SDIVS;
      end
      ST_U_SDIVS: begin
        div_req.start    = 1'b1;
        div_req.dividend = {16'b0, mul_q[63:32]};
        div_req.divisor  = {28'b0, kser_q};
        state_d          = ST_U_SDIV;
      end
      ST_U_SDIV: begin
        if (div_rsp.done) begin
          sum_d  = sum_q + {2'b0, div_rsp.quotient[31:0]};
          if (kser_q == SERIES_TERMS) begin
            state_d = ST_U_SHIFT;
          end else begin
            kser_d  = kser_q + 1'b1;
            mul_a   = $signed({1'b0, div_rsp.quotient[31:0]});
            mul_b   = $signed({1'b0, u_q});
            state_d = ST_U_SDIVS;
          end
        end
      end
      ST_U_SHIFT: begin
        if (nexp_q >= 8'sd16) tv_d = TERM_CAP;
        else                  tv_d = 33'(sum_q >> shamt[6:0]);
        state_d = ST_U_FIT;
      end
      ST_U_FIT: begin
        fit_we    = 1'b1;
        fit_waddr = k_q;
        fit_wdata = (fsum > 34'sh07FFFFFFF) ? 32'sh7FFFFFFF : fsum[31:0];
        do_uadv   = 1'b1;
      end
      ST_FINISH: begin
        loaded_d = '0;
        pos_d    = '0;
        alive_d  = '0;
        for (int o = 0; o < MAX_OBJECTIVES; o++) begin
          omax_d[o] = 32'sh80000000;
          omin_d[o] = 32'sh7FFFFFFF;
        end
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_nadv) begin
      if (!j_last) begin
        j_d     = j_q + 1'b1;
        state_d = ST_N_RD;
      end else begin
        j_d = '0;
        if (!i_last) begin
          i_d     = i_q + 1'b1;
          state_d = ST_N_RD;
        end else begin
          i_d     = '0;
          k_d     = '0;
          sacc_d  = '0;
          state_d = ST_S_RD;
        end
      end
    end

    if (do_kadv) begin
      if (!k_last) begin
        k_d     = k_q + 1'b1;
        sacc_d  = s_new;
        state_d = ST_S_RD;
      end else begin
        sc_we    = 1'b1;
        sc_wdata = s_new;
        sacc_d   = '0;
        k_d      = '0;
        if (!i_last) begin
          i_d     = i_q + 1'b1;
          state_d = ST_S_RD;
        end else begin
          i_d     = '0;
          found_d = 1'b0;
          state_d = ST_F_RD;
        end
      end
    end

    if (do_uadv) begin
      if (!k_last) begin
        k_d     = k_q + 1'b1;
        state_d = ST_U_CHK;
      end else begin
        i_d     = '0;
        found_d = 1'b0;
        state_d = ST_F_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keep_q      <= 6'd32;
      objn_q      <= 4'd2;
      loaded_q    <= '0;
      pos_q       <= '0;
      for (int o = 0; o < MAX_OBJECTIVES; o++) begin
        omax_q[o] <= 32'sh80000000;
        omin_q[o] <= 32'sh7FFFFFFF;
      end
      alive_q     <= '0;
      alive_cnt_q <= '0;
      i_q         <= '0;
      k_q         <= '0;
      e_q         <= '0;
      j_q         <= '0;
      found_q     <= 1'b0;
      kser_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      keep_q      <= keep_d;
      objn_q      <= objn_d;
      loaded_q    <= loaded_d;
      pos_q       <= pos_d;
      omax_q      <= omax_d;
      omin_q      <= omin_d;
      alive_q     <= alive_d;
      alive_cnt_q <= alive_cnt_d;
      i_q         <= i_d;
      k_q         <= k_d;
      e_q         <= e_d;
      j_q         <= j_d;
      found_q     <= found_d;
      kser_q      <= kser_d;
      res_valid_q <= res_valid_d;
    end
  end

  // datapath words
  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    sacc_q <= sacc_d;
    efit_q <= efit_d;
    se_q   <= se_d;
    nexp_q <= nexp_d;
    u_q    <= u_d;
    sum_q  <= sum_d;
    tv_q   <= tv_d;
    mul_q  <= mul_a * mul_b;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (obj_we) obj_mem[obj_waddr] <= cmd_i.obj_value;
    obj_rd_q <= obj_mem[obj_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (norm_we) norm_mem[norm_waddr] <= norm_wdata;
    norm_a_q <= norm_mem[norm_ra];
    norm_b_q <= norm_mem[norm_rb];
  end

  always_ff @(posedge clk_i) begin
    if (fit_we) fit_mem[fit_waddr] <= fit_wdata;
    if (fit_re) fit_rd_q <= fit_mem[fit_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sc_we) sc_mem[i_q] <= sc_wdata;
    if (sc_re) sc_rd_q <= sc_mem[e_q];
  end

endmodule

// ===== hdl/ibss_checker.sv =====
// port level checks of the survivor selection core, bound to the top level
`include "indicator_based_survivor_selection_core_assert.svh"

module ibss_checker import ibss_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         start_i,
  input ibss_cmd_t    cmd_i,
  input logic         busy_o,
  input logic         result_valid_o,
  input ibss_result_t result_o
);

  `IBSS_ASSERT_SAME(a_result_while_busy, clk_i, rst_ni, result_valid_o, busy_o)
  `IBSS_ASSERT_SAME(a_empty_is_last, clk_i, rst_ni,
                    result_valid_o && !result_o.removed_valid, result_o.last_result)
  `IBSS_ASSERT_NEXT(a_run_starts, clk_i, rst_ni,
                    start_i && !busy_o && cmd_i.last_individual, busy_o)
  `IBSS_ASSERT_NEXT(a_load_stays_idle, clk_i, rst_ni,
                    start_i && !busy_o && !cmd_i.last_individual, !busy_o)
  `IBSS_ASSERT_NEXT(a_run_ends, clk_i, rst_ni,
                    result_valid_o && result_o.last_result, !busy_o)

endmodule

bind indicator_based_survivor_selection_core ibss_checker u_ibss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .cmd_i          (cmd_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// ===== tb/sv/indicator_based_survivor_selection_core_test.sv =====
// testbench for the survivor selection core: directed table, random populations, self-checking
`timescale 1ns / 1ps

module indicator_based_survivor_selection_core_test;
  import ibss_pkg::*;

  logic         clk_i;
  logic         rst_ni;
  logic         start_i;
  ibss_cmd_t    cmd_i;
  logic         busy_o;
  logic         result_valid_o;
  ibss_result_t result_o;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i;
  logic [7:0]   cfg_data_i;

  indicator_based_survivor_selection_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (cmd_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // selection state mirrored from the block
  bit [5:0]     keep_reg;
  bit [3:0]     objc_reg;
  int           obj_mem [MAX_POPULATION*MAX_OBJECTIVES];
  bit           slot_written [MAX_POPULATION*MAX_OBJECTIVES];
  int           fit_mem [MAX_POPULATION];
  longint       scale_mem [MAX_POPULATION];
  bit           alive [MAX_POPULATION];
  int           obj_hi [MAX_OBJECTIVES];
  int           obj_lo [MAX_OBJECTIVES];
  longint       normed [MAX_POPULATION][MAX_OBJECTIVES];
  int unsigned  n_loaded;
  int unsigned  obj_pos;

  ibss_result_t removals_due [$];
  int           mismatches;

  function automatic int used_objectives();
    if (objc_reg == 0) return 1;
    if (objc_reg > MAX_OBJECTIVES) return MAX_OBJECTIVES;
    return int'(objc_reg);
  endfunction

  function automatic longint floor_quot(longint v, longint d);
    longint q;
    q = v / d;
    if ((v % d) != 0 && v < 0) q = q - 1;
    return q;
  endfunction

  // exp(a) in q16.16 via 2^n * 2^f, f expanded as a series in q32
  function automatic bit [63:0] exp_term(longint a);
    longint    y, n, f;
    bit [63:0] u, term, sum;
    if (a > 16 * 65536) return 64'h1_0000_0000;
    if (a < -30 * 65536) return 64'd0;
    y = floor_quot(a * 94548, 65536);
    n = floor_quot(y, 65536);
    f = y - n * 65536;
    u = (64'(f) * 64'd2977044472) >> 16;
    term = 64'h1_0000_0000;
    sum = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * u) >> 32) / 64'(k);
      sum = sum + term;
    end
    if (n >= 16) return 64'h1_0000_0000;
    return sum >> (16 - n);
  endfunction

  // additive epsilon indicator of a against b
  function automatic longint eps_of(int a, int b, int m);
    longint best, d;
    best = normed[a][0] - normed[b][0];
    for (int j = 1; j < m; j++) begin
      d = normed[a][j] - normed[b][j];
      if (d > best) best = d;
    end
    return best;
  endfunction

  function automatic void clear_population();
    for (int j = 0; j < MAX_OBJECTIVES; j++) begin
      obj_hi[j] = 32'sh8000_0000;
      obj_lo[j] = 32'sh7fff_ffff;
    end
    for (int i = 0; i < MAX_POPULATION; i++) alive[i] = 1'b0;
    n_loaded = 0;
    obj_pos = 0;
  endfunction

  function automatic void select_survivors();
    int           n, m, keep, e, left, count;
    longint       lo, hi, v, q, s, t, sum;
    bit [63:0]    term;
    ibss_result_t r;
    n = int'(n_loaded);
    m = used_objectives();
    keep = (keep_reg == 0) ? 1 : int'(keep_reg);
    count = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < m; j++) begin
        lo = obj_lo[j];
        hi = obj_hi[j];
        v = obj_mem[i*MAX_OBJECTIVES + j];
        q = 0;
        if (hi > lo) begin
          if (v <= lo) q = 0;
          else if (v >= hi) q = 65536;
          else q = (v - lo) * 65536 / (hi - lo);
        end
        normed[i][j] = q;
      end
    for (int i = 0; i < n; i++) begin
      s = 0;
      for (int k = 0; k < n; k++)
        if (k != i) begin
          t = eps_of(k, i, m);
          if (t < 0) t = -t;
          if (t > s) s = t;
        end
      scale_mem[i] = s;
    end
    left = n;
    while (left > keep) begin
      e = -1;
      for (int i = 0; i < n; i++)
        if (alive[i] && (e < 0 || fit_mem[i] < fit_mem[e])) e = i;
      alive[e] = 1'b0;
      left--;
      for (int k = 0; k < n; k++)
        if (alive[k]) begin
          term = 0;
          if (scale_mem[e] != 0) begin
            t = eps_of(e, k, m);
            term = exp_term((-20 * t * 65536) / scale_mem[e]);
          end
          sum = longint'(fit_mem[k]) + longint'(term);
          if (sum > 64'sd2147483647) sum = 64'sd2147483647;
          fit_mem[k] = int'(sum);
        end
      r.removed_index = 6'(e);
      r.removed_valid = 1'b1;
      r.last_result = (left <= keep);
      removals_due.push_back(r);
      count++;
    end
    if (count == 0) begin
      r = '0;
      r.last_result = 1'b1;
      removals_due.push_back(r);
    end
    clear_population();
  endfunction

  function automatic void absorb_word(ibss_cmd_t w);
    int p;
    if (n_loaded < MAX_POPULATION) begin
      p = int'(obj_pos);
      obj_mem[n_loaded*MAX_OBJECTIVES + p] = w.obj_value;
      slot_written[n_loaded*MAX_OBJECTIVES + p] = 1'b1;
      if (p == 0) begin
        fit_mem[n_loaded] = w.fitness_value;
        alive[n_loaded] = 1'b1;
      end
      if (w.obj_value > obj_hi[p]) obj_hi[p] = w.obj_value;
      if (w.obj_value < obj_lo[p]) obj_lo[p] = w.obj_value;
      if (w.last_objective || w.last_individual) begin
        n_loaded++;
        obj_pos = 0;
      end else if (p + 1 < MAX_OBJECTIVES) begin
        obj_pos = p + 1;
      end
    end
    if (w.last_individual) select_survivors();
  endfunction

  // result checker
  always @(posedge clk_i) begin
    ibss_result_t want;
    if (rst_ni && result_valid_o) begin
      if (removals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", result_o);
      end else begin
        want = removals_due.pop_front();
        if (result_o.removed_index !== want.removed_index
            || result_o.removed_valid !== want.removed_valid
            || result_o.last_result !== want.last_result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected idx %0d valid %0b last %0b, got idx %0d valid %0b last %0b",
                     want.removed_index, want.removed_valid, want.last_result,
                     result_o.removed_index, result_o.removed_valid, result_o.last_result);
        end
      end
    end
  end

  bit no_idle;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 200);
  endfunction

  task automatic send_word(ibss_cmd_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= w;
    do @(posedge clk_i); while (busy_o);
    absorb_word(w);
  endtask

  // hold the sender until every removal has come back and the block is idle
  task automatic drain();
    start_i <= 1'b0;
    while (removals_due.size() != 0 || busy_o) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(bit [7:0] kd, bit [7:0] md);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_KEEP_COUNT;
    cfg_data_i <= kd;
    do @(posedge clk_i); while (!cfg_ready_o);
    keep_reg = kd[5:0];
    cfg_index_i <= CFG_OBJECTIVE_COUNT;
    cfg_data_i <= md;
    do @(posedge clk_i); while (!cfg_ready_o);
    objc_reg = md[3:0];
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 32'sh7fff_ffff;
    if (r < 8) return 32'sh8000_0000;
    if (r < 10) return 0;
    if (r < 50) return ($urandom_range(0, 16) - 8) * 65536 + $urandom_range(0, 65535);
    return $urandom;
  endfunction

  function automatic int rand_fitness();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 20) return 65536;
    if (r < 30) return -65536;
    return rand_value();
  endfunction

  // directed stimulus table
  typedef struct {
    bit           is_cfg;
    bit [7:0]     keep_d;
    bit [7:0]     objc_d;
    ibss_cmd_t    w;
    bit           typed;
    ibss_result_t want;
  } step_row_t;

  step_row_t plan [$];

  function automatic void add_word(int v, int fit, bit lo, bit li, bit typed);
    step_row_t s;
    s = '{default: '0};
    s.w.obj_value = v;
    s.w.fitness_value = fit;
    s.w.last_objective = lo;
    s.w.last_individual = li;
    s.typed = typed;
    s.want.last_result = 1'b1;
    plan.push_back(s);
  endfunction

  function automatic void add_cfg(bit [7:0] kd, bit [7:0] md);
    step_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.keep_d = kd;
    s.objc_d = md;
    plan.push_back(s);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(64'd300_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int        sent, run_no, n, m, keep, cnt, c, r, base, held;
    bit        ok;
    bit [7:0]  kd, md;
    ibss_cmd_t w;
    rst_ni = 1'b0;
    start_i = 1'b0;
    cmd_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_KEEP_COUNT;
    cfg_data_i = '0;
    mismatches = 0;
    no_idle = 1'b0;
    keep_reg = 6'd32;
    objc_reg = 4'd2;
    for (int i = 0; i < MAX_POPULATION*MAX_OBJECTIVES; i++) begin
      obj_mem[i] = 0;
      slot_written[i] = 1'b0;
    end
    clear_population();

    // two individuals at the value extremes, nothing to remove
    add_word(32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0);
    add_word(32'sh8000_0000, 0, 1, 0, 0);
    add_word(32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0);
    add_word(32'sh7fff_ffff, 0, 1, 1, 1);
    // second objective has zero spread, fitness all tied
    add_cfg(8'd1, 8'd2);
    add_word(5 * 65536, 0, 0, 0, 0);
    add_word(3 * 65536, 0, 1, 0, 0);
    add_word(1 * 65536, 0, 0, 0, 0);
    add_word(3 * 65536, 0, 1, 0, 0);
    add_word(-2 * 65536, 0, 0, 0, 0);
    add_word(3 * 65536, 0, 1, 1, 0);
    // keep count and objective count of zero, extra objectives
    add_cfg(8'd0, 8'd0);
    add_word(9 * 65536, 4 * 65536, 0, 0, 0);
    add_word(1, 0, 0, 0, 0);
    add_word(2, 0, 1, 0, 0);
    add_word(-9999 * 65536, -9 * 65536, 1, 1, 0);
    // single individual, nothing to remove
    add_cfg(8'd63, 8'd1);
    add_word(42, 42, 1, 1, 1);
    // identical individuals give zero scale
    add_cfg(8'd1, 8'd1);
    add_word(5 * 65536, 3, 1, 0, 0);
    add_word(5 * 65536, -3, 1, 0, 0);
    add_word(5 * 65536, 3, 1, 1, 0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_cfg(plan[i].keep_d, plan[i].objc_d);
      end else begin
        held = removals_due.size();
        send_word(plan[i].w);
        if (plan[i].typed) begin
          while (removals_due.size() > held) void'(removals_due.pop_back());
          removals_due.push_back(plan[i].want);
        end
      end
    end

    sent = 0;
    run_no = 0;
    while (sent < 470) begin
      run_no++;
      if (run_no == 3) begin
        // overfull population at the largest keep count
        n = MAX_POPULATION + 2;
        kd = 8'd63;
        md = 8'd1;
      end else begin
        n = $urandom_range(2, 10);
        r = $urandom_range(0, 99);
        if (r < 70) keep = $urandom_range(1, n - 1);
        else if (r < 80) keep = 0;
        else keep = $urandom_range(n, 63);
        r = $urandom_range(0, 99);
        if (r < 10) c = 0;
        else if (r < 20) c = $urandom_range(9, 15);
        else if (r < 35) c = 8;
        else c = $urandom_range(1, 7);
        kd = {2'($urandom_range(0, 3)), 6'(keep)};
        md = {4'($urandom_range(0, 15)), 4'(c)};
      end
      drain();
      write_cfg(kd, md);
      no_idle = ($urandom_range(0, 3) == 0);
      m = used_objectives();
      for (int i = 0; i < n; i++) begin
        cnt = m;
        r = $urandom_range(0, 99);
        if (r < 10) begin
          cnt = m + $urandom_range(1, 3);
        end else if (r < 25 && m > 1 && n_loaded < MAX_POPULATION) begin
          // fewer objectives only where the skipped slots hold older values
          c = $urandom_range(1, m - 1);
          base = int'(n_loaded) * MAX_OBJECTIVES;
          ok = 1'b1;
          for (int j = c; j < m; j++) if (!slot_written[base + j]) ok = 1'b0;
          if (ok) cnt = c;
        end
        for (int j = 0; j < cnt; j++) begin
          w.obj_value = rand_value();
          w.fitness_value = rand_fitness();
          w.last_objective = (j == cnt - 1);
          w.last_individual = (j == cnt - 1) && (i == n - 1);
          if (n_loaded < MAX_POPULATION) sent++;
          send_word(w);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
